>>> rtl/ewt_pkg.sv
// Shared types, constants and state codes of the exponential wait time generator.
// No dependencies; every other file imports this package.
package ewt_pkg;

  localparam int UNIFORM_BITS_DEF = 24;
  localparam int IN_W             = 24;
  localparam int MEAN_W           = 24;
  localparam int LOG_FRAC_BITS    = 48;
  localparam int SQ_STEPS         = 3;
  localparam int LN_STEPS         = 4;
  localparam logic [23:0] MEAN_RESET = 24'd65536;
  localparam logic [63:0] LN2_Q64    = 64'hB17217F7D1CF79AC;
  localparam logic [47:0] WAIT_TOTAL_MAX  = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] WHOLE_TOTAL_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [23:0] uniform_value;
    logic        last;
  } ewt_in_t;

  typedef struct packed {
    logic [31:0] wait_time;
    logic [15:0] wait_whole;
    logic [47:0] wait_total;
    logic [31:0] whole_total;
  } ewt_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NORM,
    S_SQ,
    S_TCALC,
    S_LN,
    S_SCALE,
    S_ACC
  } ewt_state_t;

endpackage

>>> rtl/ewt_front.sv
// Input side: accepts requests, masks the uniform value and holds them in a
// two-entry queue for the back end. Depends on ewt_pkg.
module ewt_front #(
  parameter int UNIFORM_BITS = ewt_pkg::UNIFORM_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ewt_pkg::ewt_in_t in_item,
  output logic            q_valid,
  output ewt_pkg::ewt_in_t q_item,
  input  logic            q_pop
);
  import ewt_pkg::*;

  localparam int KEEP = (UNIFORM_BITS < IN_W) ? UNIFORM_BITS : IN_W;
  localparam logic [IN_W-1:0] MASK = (KEEP == IN_W) ? {IN_W{1'b1}} :
                                     IN_W'((64'd1 << KEEP) - 64'd1);

  ewt_in_t     mem_r [2];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;
  ewt_in_t     clean;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];

  always_comb begin
    clean               = in_item;
    clean.uniform_value = in_item.uniform_value & MASK;
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= clean;
    end
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> cnt_r != 2'd0) else $error("pop from empty queue");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> cnt_r == $past(cnt_r) + 2'd1) else $error("push lost");
`endif

endmodule

>>> rtl/ewt_back.sv
// Back end: log2 by repeated squaring on one shared 32x32 multiplier, scaling
// by the mean, running sums and the output register. Depends on ewt_pkg.
module ewt_back #(
  parameter int UNIFORM_BITS = ewt_pkg::UNIFORM_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  ewt_pkg::ewt_in_t q_item,
  output logic             q_pop,
  input  logic [23:0]      mean_wait,
  output logic             out_valid,
  input  logic             out_ready,
  output ewt_pkg::ewt_out_t out_item
);
  import ewt_pkg::*;

  localparam logic [32:0] FULL = 33'(64'd1 << UNIFORM_BITS);
  localparam logic [5:0]  BW   = 6'(UNIFORM_BITS);

  ewt_state_t  state_r, state_nxt;
  logic [2:0]  ph_r, ph_nxt;
  logic [5:0]  k_r, k_nxt;
  logic [5:0]  e_r, e_nxt;
  logic [63:0] f_r, f_nxt;
  logic [47:0] frac_r, frac_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [63:0] t_r, t_nxt;
  logic [29:0] l_r, l_nxt;
  logic [31:0] wait_r, wait_nxt;
  logic        last_r, last_nxt;
  logic [47:0] wacc_r, wacc_nxt;
  logic [31:0] hacc_r, hacc_nxt;
  logic        ov_r, ov_nxt;
  ewt_out_t    oi_r, oi_nxt;

  logic [31:0] mul_a, mul_b;
  logic [127:0] addend, acc_sum;
  logic [32:0] m;
  logic        slot_free, sq_done, ln_done;
  logic [63:0] hi_rnd;
  logic [48:0] wsum;
  logic [32:0] hsum;
  logic [15:0] whole;

  assign slot_free = !ov_r || out_ready;
  assign sq_done   = (state_r == S_SQ) && (ph_r == 3'(SQ_STEPS)) &&
                     (k_r == 6'(LOG_FRAC_BITS - 1));
  assign ln_done   = (state_r == S_LN) && (ph_r == 3'(LN_STEPS));
  assign out_valid = ov_r;
  assign out_item  = oi_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (q_valid) state_nxt = S_NORM;
      S_NORM:  if (f_r[63]) state_nxt = S_SQ;
      S_SQ:    if (sq_done) state_nxt = S_TCALC;
      S_TCALC: state_nxt = S_LN;
      S_LN:    if (ln_done) state_nxt = S_SCALE;
      S_SCALE: if (ph_r == 3'd1) state_nxt = S_ACC;
      S_ACC:   if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state_r == S_IDLE) && q_valid;
    mul_a = 32'd0;
    mul_b = 32'd0;
    addend = 128'd0;
    case (state_r)
      S_SQ: begin
        case (ph_r)
          3'd0: begin mul_a = f_r[31:0]; mul_b = f_r[31:0]; end
          3'd1: begin mul_a = f_r[31:0]; mul_b = f_r[63:32]; addend = 128'(prod_r); end
          3'd2: begin
            mul_a = f_r[63:32]; mul_b = f_r[63:32];
            addend = 128'(prod_r) << 33;
          end
          default: addend = 128'(prod_r) << 64;
        endcase
      end
      S_LN: begin
        case (ph_r)
          3'd0: begin mul_a = t_r[31:0]; mul_b = LN2_Q64[31:0]; end
          3'd1: begin
            mul_a = t_r[31:0]; mul_b = LN2_Q64[63:32]; addend = 128'(prod_r);
          end
          3'd2: begin
            mul_a = t_r[63:32]; mul_b = LN2_Q64[31:0];
            addend = 128'(prod_r) << 32;
          end
          3'd3: begin
            mul_a = t_r[63:32]; mul_b = LN2_Q64[63:32];
            addend = 128'(prod_r) << 32;
          end
          default: addend = 128'(prod_r) << 64;
        endcase
      end
      S_SCALE: begin
        mul_a = {2'b0, l_r};
        mul_b = {8'b0, mean_wait};
      end
      default: ;
    endcase
  end

  always_comb begin
    prod_nxt = {32'd0, mul_a} * {32'd0, mul_b};
    acc_sum  = ((ph_r == 3'd1) ? 128'd0 : acc_r) + addend;
    m        = FULL - {9'd0, q_item.uniform_value};
    hi_rnd   = acc_sum[127:64] + 64'h80_0000;
    wsum     = {1'b0, wacc_r} + {17'd0, wait_r};
    hsum     = {1'b0, hacc_r} + {17'd0, wait_r[31:16]};
    whole    = wait_r[31:16];
    ph_nxt   = ph_r;
    k_nxt    = k_r;
    e_nxt    = e_r;
    f_nxt    = f_r;
    frac_nxt = frac_r;
    acc_nxt  = acc_r;
    t_nxt    = t_r;
    l_nxt    = l_r;
    wait_nxt = wait_r;
    last_nxt = last_r;
    wacc_nxt = wacc_r;
    hacc_nxt = hacc_r;
    ov_nxt   = ov_r && !out_ready;
    oi_nxt   = oi_r;
    case (state_r)
      S_IDLE: begin
        f_nxt    = {31'd0, m} << (63 - UNIFORM_BITS);
        e_nxt    = BW;
        last_nxt = q_item.last;
        k_nxt    = 6'd0;
        ph_nxt   = 3'd0;
        frac_nxt = 48'd0;
      end
      S_NORM: begin
        if (!f_r[63]) begin
          f_nxt = f_r << 1;
          e_nxt = e_r - 6'd1;
        end
      end
      S_SQ: begin
        if (ph_r != 3'd0) acc_nxt = acc_sum;
        if (ph_r == 3'(SQ_STEPS)) begin
          ph_nxt   = 3'd0;
          k_nxt    = k_r + 6'd1;
          frac_nxt = {frac_r[46:0], acc_sum[127]};
          f_nxt    = acc_sum[127] ? acc_sum[127:64] : acc_sum[126:63];
        end else begin
          ph_nxt = ph_r + 3'd1;
        end
      end
      S_TCALC: begin
        t_nxt  = ({58'd0, BW - e_r} << LOG_FRAC_BITS) - {16'd0, frac_r};
        ph_nxt = 3'd0;
      end
      S_LN: begin
        if (ph_r != 3'd0) acc_nxt = acc_sum;
        if (ln_done) begin
          l_nxt  = hi_rnd[53:24];
          ph_nxt = 3'd0;
        end else begin
          ph_nxt = ph_r + 3'd1;
        end
      end
      S_SCALE: begin
        if (ph_r == 3'd1) begin
          wait_nxt = (|prod_r[63:56]) ? 32'hFFFF_FFFF : prod_r[55:24];
          ph_nxt   = 3'd0;
        end else begin
          ph_nxt = 3'd1;
        end
      end
      S_ACC: begin
        if (slot_free) begin
          oi_nxt.wait_time   = wait_r;
          oi_nxt.wait_whole  = whole;
          oi_nxt.wait_total  = wsum[48] ? WAIT_TOTAL_MAX : wsum[47:0];
          oi_nxt.whole_total = hsum[32] ? WHOLE_TOTAL_MAX : hsum[31:0];
          ov_nxt   = 1'b1;
          wacc_nxt = last_r ? 48'd0 : oi_nxt.wait_total;
          hacc_nxt = last_r ? 32'd0 : oi_nxt.whole_total;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ph_r    <= 3'd0;
      k_r     <= 6'd0;
      wacc_r  <= 48'd0;
      hacc_r  <= 32'd0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      k_r     <= k_nxt;
      wacc_r  <= wacc_nxt;
      hacc_r  <= hacc_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r    <= e_nxt;
    f_r    <= f_nxt;
    frac_r <= frac_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
    t_r    <= t_nxt;
    l_r    <= l_nxt;
    wait_r <= wait_nxt;
    last_r <= last_nxt;
    oi_r   <= oi_nxt;
  end

`ifndef SYNTHESIS
  a_sq_phase: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SQ |-> ph_r <= 3'(SQ_STEPS)) else $error("square phase overrun");
  a_acc_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC && slot_free) |=> (state_r == S_IDLE && ov_r))
    else $error("result not registered");
  a_whole: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> oi_r.wait_whole == oi_r.wait_time[31:16]) else $error("whole mismatch");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == S_NORM) else $error("pop outside idle");
`endif

endmodule

>>> rtl/exponential_wait_time_generator.sv
// Exponential wait time generator: for each uniform fraction u it returns
// -ln(1-u)*mean_wait in Q16.16 with integer part and saturating run totals.
// An item leaving the queue goes through setup, up to UNIFORM_BITS normalize
// shifts (one per leading zero of 1-u), 48 log2 squarings on the one shared
// 32x32 multiplier, ln2 scaling, the mean multiply and accumulation. A result
// held by a stalled receiver delays the next accumulation. A two-entry input
// queue accepts requests meanwhile; the output register holds a result while
// the next item is computed.
module exponential_wait_time_generator #(
  parameter int UNIFORM_BITS = ewt_pkg::UNIFORM_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ewt_pkg::ewt_in_t  in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output ewt_pkg::ewt_out_t out_item,
  input  logic              cfg_we,
  input  logic [23:0]       cfg_wdata
);
  import ewt_pkg::*;

  logic        q_valid, q_pop;
  ewt_in_t     q_item;
  logic [23:0] mean_r, mean_nxt;

  assign mean_nxt = cfg_we ? cfg_wdata : mean_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r <= MEAN_RESET;
    end else begin
      mean_r <= mean_nxt;
    end
  end

  ewt_front #(.UNIFORM_BITS(UNIFORM_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  ewt_back #(.UNIFORM_BITS(UNIFORM_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .mean_wait (mean_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
